// File: sv/buffered_serial_fifo_pair_unit_defines.svh
// Assertion macros for the buffered serial FIFO pair unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BUFFERED_SERIAL_FIFO_PAIR_UNIT_DEFINES_SVH
`define BUFFERED_SERIAL_FIFO_PAIR_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset
`define BSFP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsfp: same-cycle check failed");

// Next-cycle implication, off during reset
`define BSFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsfp: next-cycle check failed");

`endif

// File: sv/bsfp_pkg.sv
// Package for the buffered serial FIFO pair unit: sizes, codes, item structs.
// No dependencies; imported by every module of the block.
package bsfp_pkg;

  // Ring depth and derived widths
  localparam int DEPTH  = 128;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Command queue between front and back (power of two depth)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Event codes on the input item
  typedef enum logic [1:0] {
    FUNC_RX_BYTE    = 2'd0,
    FUNC_TX_READY   = 2'd1,
    FUNC_HOST_WRITE = 2'd2,
    FUNC_HOST_READ  = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RX_OVERRUN = 2'd1,
    ST_TX_FULL    = 2'd2,
    ST_RX_EMPTY   = 2'd3
  } status_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_RX_PUSH   = 3'd0,
    OP_TX_POP    = 3'd1,
    OP_TX_DIRECT = 3'd2,
    OP_TX_PUSH   = 3'd3,
    OP_RX_POP    = 3'd4
  } op_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RESP = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       port_ready;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [7:0] rx_fill;
    logic [7:0] tx_fill;
    logic       rts_out;
    logic       tx_irq_enable;
  } out_item_t;

  // Queue entry
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Ring control from back to a ring
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wr_data;
  } ring_ctl_t;

  // Ring status back to the back end
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } ring_sts_t;

  // Ring pointer advance with wrap at DEPTH
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] inc;
    inc = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return inc[PTR_W-1:0];
  endfunction

  // Low eight bits of a fill count
  function automatic logic [7:0] fill8(input logic [CNT_W-1:0] c);
    logic [CNT_W+7:0] w;
    w = {8'b0, c};
    return w[7:0];
  endfunction

endpackage

// File: sv/bsfp_front.sv
// Front end: accepts items, classifies each event, queues the command.
// Depends on bsfp_pkg.
module bsfp_front import bsfp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output logic     q_valid,
  output cmd_t     q_head,
  input  logic     q_pop
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  cmd_t              cmd;

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign accept  = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_r[rd_ptr_r];

  // Classify: host write splits on port_ready
  always_comb begin
    cmd.data = in_item.data_byte;
    case (func_t'(in_item.func))
      FUNC_RX_BYTE:    cmd.op = OP_RX_PUSH;
      FUNC_TX_READY:   cmd.op = OP_TX_POP;
      FUNC_HOST_WRITE: cmd.op = in_item.port_ready ? OP_TX_DIRECT : OP_TX_PUSH;
      FUNC_HOST_READ:  cmd.op = OP_RX_POP;
      default:         cmd.op = OP_RX_POP;
    endcase
  end

  // Queue pointers (depth is a power of two, so plain increment wraps)
  always_comb begin
    wr_ptr_nxt = accept ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept && !q_pop)      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    else if (!accept && q_pop) cnt_nxt = QCNT_W'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) q_r[wr_ptr_r] <= cmd;
  end

endmodule

// File: sv/bsfp_ring.sv
// One byte ring: memory, head/tail pointers and fill count.
// Depends on bsfp_pkg; read data is registered and appears in the cycle after pop.
module bsfp_ring import bsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ring_ctl_t  ctl,
  output ring_sts_t  sts,
  output logic [7:0] rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign sts.count = count_r;
  assign sts.full  = (count_r == CNT_W'(DEPTH));
  assign sts.empty = (count_r == '0);
  assign rd_data   = rd_data_r;

  // Pointer and count update; back end never pushes and pops together
  always_comb begin
    head_nxt  = ctl.pop  ? next_ptr(head_r) : head_r;
    tail_nxt  = ctl.push ? next_ptr(tail_r) : tail_r;
    count_nxt = count_r;
    if (ctl.push)     count_nxt = CNT_W'(count_r + 1'b1);
    else if (ctl.pop) count_nxt = CNT_W'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.push) mem[tail_r] <= ctl.wr_data;
    if (ctl.pop)  rd_data_r   <= mem[head_r];
  end

endmodule

// File: sv/bsfp_back.sv
// Back end: executes queued commands on the two rings, drives RTS, IRQ
// enable and the result strobe. Depends on bsfp_pkg and bsfp_ring.
module bsfp_back import bsfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_head,
  output logic      q_pop,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  output logic      out_valid,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;

  ring_ctl_t  rx_ctl, tx_ctl;
  ring_sts_t  rx_sts, tx_sts;
  logic [7:0] rx_rd, tx_rd;

  logic       fc_r;
  logic       rts_r, rts_nxt;
  logic       irq_r, irq_nxt;

  // Per-item response fields, latched at execute
  logic       send_v_r, send_v_nxt;
  logic       direct_r, direct_nxt;
  logic       read_v_r, read_v_nxt;
  status_t    status_r, status_nxt;
  logic [7:0] data_r;

  bsfp_ring u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rx_ctl),
    .sts     (rx_sts),
    .rd_data (rx_rd)
  );

  bsfp_ring u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tx_ctl),
    .sts     (tx_sts),
    .rd_data (tx_rd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_RESP;
      BK_RESP: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Execute: decide ring action and flags for the queue head
  always_comb begin
    q_pop          = (state_r == BK_IDLE) && q_valid;
    rx_ctl.push    = 1'b0;
    rx_ctl.pop     = 1'b0;
    rx_ctl.wr_data = q_head.data;
    tx_ctl.push    = 1'b0;
    tx_ctl.pop     = 1'b0;
    tx_ctl.wr_data = q_head.data;
    rts_nxt        = rts_r;
    irq_nxt        = irq_r;
    send_v_nxt     = 1'b0;
    direct_nxt     = 1'b0;
    read_v_nxt     = 1'b0;
    status_nxt     = ST_OK;
    if (q_pop) begin
      case (q_head.op)
        OP_RX_PUSH: begin
          if (rx_sts.full) status_nxt = ST_RX_OVERRUN;
          else rx_ctl.push = 1'b1;
          // RTS low once the ring is full after this byte
          if (fc_r) rts_nxt = !(rx_sts.full || rx_sts.count == CNT_W'(DEPTH - 1));
        end
        OP_TX_POP: begin
          if (!tx_sts.empty) begin
            tx_ctl.pop = 1'b1;
            send_v_nxt = 1'b1;
            irq_nxt    = 1'b1;
          end else begin
            irq_nxt    = 1'b0;
          end
          if (fc_r) rts_nxt = !rx_sts.full;
        end
        OP_TX_DIRECT: begin
          send_v_nxt = 1'b1;
          direct_nxt = 1'b1;
        end
        OP_TX_PUSH: begin
          if (tx_sts.full) begin
            status_nxt  = ST_TX_FULL;
          end else begin
            tx_ctl.push = 1'b1;
            irq_nxt     = 1'b1;
          end
        end
        OP_RX_POP: begin
          if (rx_sts.empty) begin
            status_nxt = ST_RX_EMPTY;
          end else begin
            rx_ctl.pop = 1'b1;
            read_v_nxt = 1'b1;
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      fc_r    <= 1'b0;
      rts_r   <= 1'b0;
      irq_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rts_r   <= rts_nxt;
      irq_r   <= irq_nxt;
      if (cfg_valid) fc_r <= cfg_data;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      send_v_r <= send_v_nxt;
      direct_r <= direct_nxt;
      read_v_r <= read_v_nxt;
      status_r <= status_nxt;
      data_r   <= q_head.data;
    end
  end

  // Result outputs; ring counts and read data have settled by now
  always_comb begin
    out_valid              = (state_r == BK_RESP);
    out_item.send_valid    = send_v_r;
    out_item.send_byte     = !send_v_r ? 8'd0 : (direct_r ? data_r : tx_rd);
    out_item.read_valid    = read_v_r;
    out_item.read_byte     = read_v_r ? rx_rd : 8'd0;
    out_item.status        = status_r;
    out_item.rx_fill       = fill8(rx_sts.count);
    out_item.tx_fill       = fill8(tx_sts.count);
    out_item.rts_out       = rts_r;
    out_item.tx_irq_enable = irq_r;
  end

endmodule

// File: sv/buffered_serial_fifo_pair_unit.sv
// Top level of the buffered serial FIFO pair unit.
// Depends on bsfp_pkg, bsfp_front, bsfp_back and the defines header.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | start / busy         | in_item  (in_item_t)
//   result   | out_valid strobe     | out_item (out_item_t)
//   config   | cfg_valid/cfg_ready  | cfg_data (flow control)
//
// In the back end each item is executed, then answered once the
// ring memory's registered read data is available; no new item is taken
// until the answer is out. A 2-entry command queue lets start be taken while
// the back end works; busy is high only when that queue is full.
// Reset is synchronous, active low, and needs no clearing pass.
// out_valid is high one cycle per item; the receiver cannot stall.
`include "buffered_serial_fifo_pair_unit_defines.svh"

module buffered_serial_fifo_pair_unit import bsfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic q_valid;
  logic q_pop;
  cmd_t q_head;
  logic rsp_rx_empty;
  logic rsp_overrun;

  // Config register is always writable
  assign cfg_ready = 1'b1;

  bsfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  bsfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Result kinds watched by the checks below
  assign rsp_rx_empty = out_valid && (out_item.status == ST_RX_EMPTY);
  assign rsp_overrun  = out_valid && (out_item.status == ST_RX_OVERRUN);

  // Result strobe is never high in back-to-back cycles
  `BSFP_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // Empty read returns no byte and reports an empty receive ring
  `BSFP_ASSERT_IMPLY(a_rx_empty, rsp_rx_empty, !out_item.read_valid && out_item.rx_fill == 8'd0)
  // A receive overrun under flow control leaves RTS low
  `BSFP_ASSERT_IMPLY(a_overrun_rts, rsp_overrun && u_back.fc_r, !out_item.rts_out)

endmodule

// File: bench/tb.sv
// Testbench for buffered_serial_fifo_pair_unit: drives port and host events,
// predicts each result from a behavioral model of both rings, checks all fields.
// Depends on bsfp_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb import bsfp_pkg::*; ();

  // Kinds of stimulus segment
  typedef enum {
    SEG_RX_FILL,
    SEG_RX_DRAIN,
    SEG_TX_FILL,
    SEG_TX_DRAIN,
    SEG_MIX
  } seg_kind_t;

  localparam int IDLE_LIMIT   = 600;
  localparam int PHASE_ITEMS  = 200;
  localparam int RAND_PHASES  = 5;
  localparam int SETTLE_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  buffered_serial_fifo_pair_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state of both rings and the port controls
  logic [7:0] rx_ring [DEPTH];
  logic [7:0] tx_ring [DEPTH];
  int         rx_rd, rx_wr, rx_cnt;
  int         tx_rd, tx_wr, tx_cnt;
  logic       irq_en_m, rts_m, flow_ctl_m;

  in_item_t   events_pending[$];
  out_item_t  port_results_due[$];
  logic       item_taken = 1'b0;
  int         fail_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         idle_cycles = 0;

  // Apply one event to the model and return the result it causes
  function automatic out_item_t next_port_result(in_item_t it);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    case (func_t'(it.func))
      FUNC_RX_BYTE: begin
        if (rx_cnt >= DEPTH) begin
          r.status = ST_RX_OVERRUN;
        end else begin
          rx_ring[rx_wr] = it.data_byte;
          rx_wr = (rx_wr + 1) % DEPTH;
          rx_cnt++;
        end
        if (flow_ctl_m) rts_m = (rx_cnt < DEPTH);
      end
      FUNC_TX_READY: begin
        if (tx_cnt > 0) begin
          r.send_valid = 1'b1;
          r.send_byte = tx_ring[tx_rd];
          tx_rd = (tx_rd + 1) % DEPTH;
          tx_cnt--;
          irq_en_m = 1'b1;
        end else begin
          irq_en_m = 1'b0;
        end
        if (flow_ctl_m) rts_m = (rx_cnt < DEPTH);
      end
      FUNC_HOST_WRITE: begin
        if (it.port_ready) begin
          r.send_valid = 1'b1;
          r.send_byte = it.data_byte;
        end else if (tx_cnt >= DEPTH) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_ring[tx_wr] = it.data_byte;
          tx_wr = (tx_wr + 1) % DEPTH;
          tx_cnt++;
          irq_en_m = 1'b1;
        end
      end
      default: begin
        if (rx_cnt == 0) begin
          r.status = ST_RX_EMPTY;
        end else begin
          r.read_valid = 1'b1;
          r.read_byte = rx_ring[rx_rd];
          rx_rd = (rx_rd + 1) % DEPTH;
          rx_cnt--;
        end
      end
    endcase
    r.rx_fill = 8'(rx_cnt);
    r.tx_fill = 8'(tx_cnt);
    r.rts_out = rts_m;
    r.tx_irq_enable = irq_en_m;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: predict on each accepted item, check each result strobe
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (port_results_due.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = port_results_due.pop_front();
        check_field("send_valid", 8'(want.send_valid), 8'(out_item.send_valid));
        check_field("send_byte", want.send_byte, out_item.send_byte);
        check_field("read_valid", 8'(want.read_valid), 8'(out_item.read_valid));
        check_field("read_byte", want.read_byte, out_item.read_byte);
        check_field("status", 8'(want.status), 8'(out_item.status));
        check_field("rx_fill", want.rx_fill, out_item.rx_fill);
        check_field("tx_fill", want.tx_fill, out_item.tx_fill);
        check_field("rts_out", 8'(want.rts_out), 8'(out_item.rts_out));
        check_field("tx_irq_enable", 8'(want.tx_irq_enable),
                    8'(out_item.tx_irq_enable));
      end
    end
    if (rst_n && start && busy === 1'b0)
      port_results_due.push_back(next_port_result(in_item));
    item_taken <= rst_n && start && busy === 1'b0;
  end

  // Driver: bursts of items with random gaps, holds an item until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (events_pending.size() != 0) begin
      in_item <= events_pending.pop_front();
      start <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic in_item_t make_event(func_t f, bit mostly_queued);
    in_item_t it;
    it.func = f;
    it.data_byte = 8'($urandom_range(0, 255));
    it.port_ready = mostly_queued ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t event_of(func_t f, logic [7:0] b, logic rdy);
    in_item_t it;
    it.func = f;
    it.data_byte = b;
    it.port_ready = rdy;
    return it;
  endfunction

  // Queue a run of events of one kind (mixed kinds for SEG_MIX), with some noise mixed in
  task automatic queue_segment(input seg_kind_t kind, input int n);
    func_t f;
    for (int i = 0; i < n; i++) begin
      case (kind)
        SEG_RX_FILL:  f = FUNC_RX_BYTE;
        SEG_RX_DRAIN: f = FUNC_HOST_READ;
        SEG_TX_FILL:  f = FUNC_HOST_WRITE;
        SEG_TX_DRAIN: f = FUNC_TX_READY;
        default:      f = func_t'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 7) == 0) f = func_t'($urandom_range(0, 3));
      events_pending.push_back(make_event(f, kind == SEG_TX_FILL));
    end
  endtask

  // Pause until every result is in, then let the unit settle
  task automatic wait_drained();
    while (events_pending.size() != 0 || start || port_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_flow_ctl(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    flow_ctl_m = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int queued;
    seg_kind_t kind;
    rx_rd = 0; rx_wr = 0; rx_cnt = 0;
    tx_rd = 0; tx_wr = 0; tx_cnt = 0;
    irq_en_m = 1'b0; rts_m = 1'b0; flow_ctl_m = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every event on empty and loaded rings, flow control off
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_TX_READY, 8'hff, 1'b1));
    events_pending.push_back(event_of(FUNC_HOST_WRITE, 8'h00, 1'b1));
    events_pending.push_back(event_of(FUNC_HOST_WRITE, 8'hff, 1'b0));
    events_pending.push_back(event_of(FUNC_HOST_WRITE, 8'ha5, 1'b0));
    events_pending.push_back(event_of(FUNC_HOST_WRITE, 8'h5a, 1'b1));
    events_pending.push_back(event_of(FUNC_TX_READY, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_TX_READY, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_TX_READY, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_RX_BYTE, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_RX_BYTE, 8'hff, 1'b0));
    events_pending.push_back(event_of(FUNC_RX_BYTE, 8'h81, 1'b1));
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'hff, 1'b1));
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'h00, 1'b0));
    wait_drained();

    // Directed: RTS follows port events only once flow control is on
    write_flow_ctl(1'b1);
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_RX_BYTE, 8'h7e, 1'b0));
    events_pending.push_back(event_of(FUNC_HOST_WRITE, 8'h3c, 1'b0));
    events_pending.push_back(event_of(FUNC_TX_READY, 8'h00, 1'b1));
    events_pending.push_back(event_of(FUNC_HOST_READ, 8'h00, 1'b0));
    events_pending.push_back(event_of(FUNC_TX_READY, 8'h00, 1'b0));
    wait_drained();

    // Random phases, flow control alternating; early ones queue fill runs of DEPTH + 6 for both rings
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_flow_ctl(1'(p % 2 == 0 ? 1 : 0));
      queued = 0;
      if (p < 2) begin
        queue_segment(SEG_RX_FILL, DEPTH + 6);
        queue_segment(SEG_TX_FILL, DEPTH + 6);
        queued = 2 * (DEPTH + 6);
      end
      while (queued < PHASE_ITEMS) begin
        int n;
        kind = seg_kind_t'($urandom_range(0, 4));
        n = $urandom_range(1, (kind == SEG_MIX) ? 60 : DEPTH + 8);
        queue_segment(kind, n);
        queued += n;
      end
      wait_drained();
    end

    write_flow_ctl(1'b0);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && port_results_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
